// File: rtl/glyph_bitmap_expander_defines.svh
// Assertion macros shared by the glyph expander RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GLYPH_BITMAP_EXPANDER_DEFINES_SVH
`define GLYPH_BITMAP_EXPANDER_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define GBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define GBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gbe_pkg.sv
// Package for the glyph bitmap expander: widths, codes, structs, colour helpers.
// No dependencies; every other RTL file but the macro header imports it.
package gbe_pkg;

  localparam int COORD_BITS  = 12;
  localparam int OFFSET_BITS = 26;
  localparam int X_W         = COORD_BITS + 1;
  localparam int LB_W        = 14;
  localparam int BASE_W      = X_W + LB_W;
  localparam int COL_W       = 24;
  localparam int DATA_W      = 32;
  localparam int LANES       = 8;
  localparam int LANE_W      = $clog2(LANES);
  localparam int CNT_W       = $clog2(LANES + 1);
  localparam int BC_W        = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [1:0] {
    DEST_8   = 2'd0,
    DEST_16  = 2'd1,
    DEST_32  = 2'd2,
    DEST_BAD = 2'd3
  } dest_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_BYTES = 3'd0,
    REG_FORMAT     = 3'd1,
    REG_FG         = 3'd2,
    REG_BG         = 3'd3,
    REG_LEFT_X     = 3'd4,
    REG_TOP_Y      = 3'd5,
    REG_END_X      = 3'd6,
    REG_END_Y      = 3'd7
  } cfg_idx_t;

  localparam logic [BC_W-1:0] BC_NONE = 3'd0;
  localparam logic [BC_W-1:0] BC_ONE  = 3'd1;
  localparam logic [BC_W-1:0] BC_TWO  = 3'd2;
  localparam logic [BC_W-1:0] BC_FOUR = 3'd4;

  typedef struct packed {
    logic [LB_W-1:0]       line_bytes;
    dest_t                 dest;
    logic                  eight;
    logic [COL_W-1:0]      fg;
    logic [COL_W-1:0]      bg;
    logic [COORD_BITS-1:0] lx;
    logic [COORD_BITS-1:0] ty;
    logic [X_W-1:0]        ex;
    logic [X_W-1:0]        ey;
  } cfg_t;

  // One accepted byte on its way to the lanes.
  typedef struct packed {
    logic [X_W-1:0]    cur_x;
    logic [BASE_W-1:0] row_base;
    logic [7:0]        src;
    logic [CNT_W-1:0]  npix;
    logic              done;
    logic              err;
  } job_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [DATA_W-1:0]      data;
  } lane_res_t;

  function automatic logic [DATA_W-1:0] fmt_color(logic [COL_W-1:0] c, dest_t d);
    logic [DATA_W-1:0] res;
    res = '0;
    case (d)
      DEST_8:  res = DATA_W'(c[7:0]);
      DEST_16: res = DATA_W'({c[23:19], c[15:10], c[7:3]});
      default: res = DATA_W'(c);
    endcase
    return res;
  endfunction

  function automatic logic [BC_W-1:0] bytes_pp(dest_t d);
    logic [BC_W-1:0] res;
    res = BC_FOUR;
    case (d)
      DEST_8:  res = BC_ONE;
      DEST_16: res = BC_TWO;
      default: res = BC_FOUR;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/gbe_ifs.sv
// Valid/ready channel interfaces for the glyph expander: source bytes in, pixel writes out.
// Depends on gbe_pkg for field widths.
interface gbe_in_if import gbe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       start_req;

  modport source (output valid, output src_byte, output start_req, input ready);
  modport sink   (input valid, input src_byte, input start_req, output ready);
endinterface

interface gbe_out_if import gbe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OFFSET_BITS-1:0] pixel_offset;
  logic [DATA_W-1:0]      pixel_data;
  logic [BC_W-1:0]        byte_count;
  logic                   last;
  logic                   glyph_done;
  logic                   format_error;

  modport source (output valid, output pixel_offset, output pixel_data, output byte_count,
                  output last, output glyph_done, output format_error, input ready);
  modport sink   (input valid, input pixel_offset, input pixel_data, input byte_count,
                  input last, input glyph_done, input format_error, output ready);
endinterface

// File: rtl/glyph_bitmap_expander.sv
// Glyph bitmap expander top level: configuration registers, walker, eight lanes, merge.
// Depends on gbe_pkg, gbe_ifs, gbe_walker, gbe_lane and gbe_merge.
//
// Usage:
//   Configure through cfg_we/cfg_idx/cfg_wdata while no byte is in flight.
//   Send glyph source bytes in row order on in_if; start_req on a byte
//   restarts at the glyph's top-left corner before that byte is used.
//   Each byte gives zero to eight pixel writes on out_if (offset, colour,
//   byte count, last, glyph_done), or a single format_error transfer when
//   the destination format is invalid.
// Path: the first write of a byte is registered in the walker stage, the
//   row-base product, the lanes and the output register, in that order.
// Throughput: out_if carries one write per cycle while out_if.ready is high;
//   a byte gives one write per pixel it fills, and the next byte waits in the
//   walker until the merge stage has sent them; the eight lanes compute all pixels
//   of a byte at once, so the merge stage feeding the single output port sets the rate.
// Reset (rst_n low, synchronous): registers take their default values,
//   position returns to 0/0 and the glyph is marked finished; no clearing pass.
// Stall: while out_if.ready is low the output register holds its write;
//   up to three further bytes queue in the pipeline, then in_if.ready drops.
module glyph_bitmap_expander import gbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  gbe_in_if.sink                in_if,
  gbe_out_if.source             out_if
);

  logic [LB_W-1:0]       line_bytes_r;
  logic [2:0]            format_r;
  logic [COL_W-1:0]      fg_r, bg_r;
  logic [COORD_BITS-1:0] left_x_r, top_y_r;
  logic [X_W-1:0]        end_x_r, end_y_r;

  cfg_t      cfg;
  job_t      job;
  logic      job_valid, job_take;
  lane_res_t lane_res [LANES];

  // register writes: take the low bits of the data word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= '0;
      format_r     <= 3'd2;
      fg_r         <= 24'hffffff;
      bg_r         <= '0;
      left_x_r     <= '0;
      top_y_r      <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_LINE_BYTES: line_bytes_r <= cfg_wdata[LB_W-1:0];
        REG_FORMAT:     format_r     <= cfg_wdata[2:0];
        REG_FG:         fg_r         <= cfg_wdata[COL_W-1:0];
        REG_BG:         bg_r         <= cfg_wdata[COL_W-1:0];
        REG_LEFT_X:     left_x_r     <= cfg_wdata[COORD_BITS-1:0];
        REG_TOP_Y:      top_y_r      <= cfg_wdata[COORD_BITS-1:0];
        REG_END_X:      end_x_r      <= cfg_wdata[X_W-1:0];
        REG_END_Y:      end_y_r      <= cfg_wdata[X_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    cfg.line_bytes = line_bytes_r;
    cfg.dest       = dest_t'(format_r[1:0]);
    cfg.eight      = format_r[2];
    cfg.fg         = fg_r;
    cfg.bg         = bg_r;
    cfg.lx         = left_x_r;
    cfg.ty         = top_y_r;
    cfg.ex         = end_x_r;
    cfg.ey         = end_y_r;
  end

  // track position, hold each byte through the row-base multiply
  gbe_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_if       (in_if),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_take_i  (job_take)
  );

  // one lane per bit of the source byte
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    gbe_lane u_lane (
      .clk        (clk),
      .cfg        (cfg),
      .job_i      (job),
      .lane_idx_i (LANE_W'(g)),
      .load_i     (job_take),
      .res_o      (lane_res[g])
    );
  end

  // serialise lane results onto the output channel
  gbe_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .res_i       (lane_res),
    .out_if      (out_if)
  );

endmodule

// File: rtl/gbe_walker.sv
// Glyph position tracker: takes source bytes, advances x/y, forms row base product.
// Depends on gbe_pkg and gbe_in_if.
module gbe_walker import gbe_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  gbe_in_if.sink in_if,
  output job_t  job_o,
  output logic  job_valid_o,
  input  logic  job_take_i
);

  logic [X_W-1:0] cur_x_r, cur_y_r;
  logic           fin_r;

  logic             s1_v_r;
  logic [X_W-1:0]   s1_cur_x_r, s1_cur_y_r;
  logic [7:0]       s1_src_r;
  logic [CNT_W-1:0] s1_npix_r;
  logic             s1_done_r, s1_err_r;

  logic s2_v_r;
  job_t job_r;

  logic             acc, s1_adv, s2_free;
  logic [X_W-1:0]   cx0, cy0, avail, adv_x, cy_inc, x_new, y_new;
  logic             fin0, fin_new, emit, err, done, row_end;
  logic [CNT_W-1:0] npix;

  assign s2_free     = !s2_v_r || job_take_i;
  assign s1_adv      = s1_v_r && s2_free;
  assign in_if.ready = !s1_v_r || s1_adv;
  assign acc         = in_if.valid && in_if.ready;

  always_comb begin
    cx0  = in_if.start_req ? X_W'(cfg.lx) : cur_x_r;
    cy0  = in_if.start_req ? X_W'(cfg.ty) : cur_y_r;
    fin0 = in_if.start_req ? ((X_W'(cfg.lx) >= cfg.ex) || (X_W'(cfg.ty) >= cfg.ey)) : fin_r;
    avail = (cx0 < cfg.ex) ? (cfg.ex - cx0) : '0;
    if (cfg.eight) begin
      npix = (avail != '0) ? CNT_W'(1) : '0;
    end else begin
      npix = (avail > X_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(avail);
    end
    adv_x   = cx0 + X_W'(npix);
    row_end = adv_x >= cfg.ex;
    cy_inc  = cy0 + X_W'(1);

    x_new   = cx0;
    y_new   = cy0;
    fin_new = fin0;
    emit    = 1'b0;
    err     = 1'b0;
    done    = 1'b0;
    if (fin0) begin
      fin_new = 1'b1;
    end else if (cy0 >= cfg.ey) begin
      fin_new = 1'b1;
    end else if (cfg.dest == DEST_BAD) begin
      // abandon the glyph, flag once
      fin_new = 1'b1;
      emit    = 1'b1;
      err     = 1'b1;
      npix    = CNT_W'(1);
    end else begin
      emit = npix != '0;
      if (row_end) begin
        x_new   = X_W'(cfg.lx);
        y_new   = cy_inc;
        fin_new = cy_inc >= cfg.ey;
        done    = fin_new && emit;
      end else begin
        x_new = adv_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      fin_r   <= 1'b1;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      if (acc) begin
        cur_x_r <= x_new;
        cur_y_r <= y_new;
        fin_r   <= fin_new;
      end
      if (acc && emit) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_r <= 1'b1;
      end else if (job_take_i) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  // payload: hold unless the stage is loaded
  always_ff @(posedge clk) begin
    if (acc && emit) begin
      s1_cur_x_r <= cx0;
      s1_cur_y_r <= cy0;
      s1_src_r   <= in_if.src_byte;
      s1_npix_r  <= npix;
      s1_done_r  <= done;
      s1_err_r   <= err;
    end
    if (s1_adv) begin
      job_r.cur_x    <= s1_cur_x_r;
      job_r.row_base <= BASE_W'(s1_cur_y_r) * BASE_W'(cfg.line_bytes);
      job_r.src      <= s1_src_r;
      job_r.npix     <= s1_npix_r;
      job_r.done     <= s1_done_r;
      job_r.err      <= s1_err_r;
    end
  end

  assign job_o       = job_r;
  assign job_valid_o = s2_v_r;

endmodule

// File: rtl/gbe_lane.sv
// One pixel lane: byte offset and formatted colour for one bit position of a byte.
// Depends on gbe_pkg.
module gbe_lane import gbe_pkg::*; (
  input  logic              clk,
  input  cfg_t              cfg,
  input  job_t              job_i,
  input  logic [LANE_W-1:0] lane_idx_i,
  input  logic              load_i,
  output lane_res_t         res_o
);

  logic [X_W-1:0]    x;
  logic [X_W+1:0]    xoff;
  logic [BASE_W-1:0] sum;
  logic              on;
  lane_res_t         res_r;

  always_comb begin
    x = job_i.cur_x + X_W'(lane_idx_i);
    case (cfg.dest)
      DEST_8:  xoff = (X_W+2)'(x);
      DEST_16: xoff = (X_W+2)'(x) << 1;
      default: xoff = (X_W+2)'(x) << 2;
    endcase
    sum = job_i.row_base + BASE_W'(xoff);
    on  = cfg.eight ? (job_i.src != 8'd0) : job_i.src[LANE_W'(LANES-1) - lane_idx_i];
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r.offset <= OFFSET_BITS'(sum);
      res_r.data   <= fmt_color(on ? cfg.fg : cfg.bg, cfg.dest);
    end
  end

  assign res_o = res_r;

endmodule

// File: rtl/gbe_merge.sv
// Merge stage: walks the lane results in order and drives the output register.
// Depends on gbe_pkg, gbe_out_if and the assertion macro header.
`include "glyph_bitmap_expander_defines.svh"

module gbe_merge import gbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  job_t      job_i,
  input  logic      job_valid_i,
  output logic      job_take_o,
  input  lane_res_t res_i [LANES],
  gbe_out_if.source out_if
);

  logic              s3_v_r;
  logic [CNT_W-1:0]  n_r;
  logic              done_r, err_r;
  logic [LANE_W-1:0] idx_r;

  logic                   out_v_r;
  logic [OFFSET_BITS-1:0] off_r;
  logic [DATA_W-1:0]      data_r;
  logic [BC_W-1:0]        bc_r;
  logic                   last_r, gdone_r, ferr_r;

  logic s3_mv, s3_end;

  assign s3_mv      = s3_v_r && (!out_v_r || out_if.ready);
  assign s3_end     = s3_mv && ((CNT_W'(idx_r) + CNT_W'(1)) == n_r);
  assign job_take_o = job_valid_i && (!s3_v_r || s3_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (job_take_o) begin
        s3_v_r <= 1'b1;
        idx_r  <= '0;
      end else if (s3_end) begin
        s3_v_r <= 1'b0;
        idx_r  <= '0;
      end else if (s3_mv) begin
        idx_r <= idx_r + LANE_W'(1);
      end
      if (s3_mv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take_o) begin
      n_r    <= job_i.npix;
      done_r <= job_i.done;
      err_r  <= job_i.err;
    end
    if (s3_mv) begin
      off_r   <= err_r ? '0 : res_i[idx_r].offset;
      data_r  <= err_r ? '0 : res_i[idx_r].data;
      bc_r    <= err_r ? BC_NONE : bytes_pp(cfg.dest);
      last_r  <= s3_end;
      gdone_r <= s3_end && done_r;
      ferr_r  <= err_r;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.pixel_offset = off_r;
  assign out_if.pixel_data   = data_r;
  assign out_if.byte_count   = bc_r;
  assign out_if.last         = last_r;
  assign out_if.glyph_done   = gdone_r;
  assign out_if.format_error = ferr_r;

  `GBE_ASSERT_IMP(a_err_shape, out_v_r && ferr_r, last_r && (bc_r == BC_NONE), "error write malformed")
  `GBE_ASSERT_IMP(a_done_last, out_v_r && gdone_r, last_r, "glyph_done without last")
  `GBE_ASSERT_IMP(a_idx_range, s3_v_r, CNT_W'(idx_r) < n_r, "lane index past pixel count")
  `GBE_ASSERT_NXT(a_end_last, s3_end, out_v_r && last_r, "final lane did not close the byte")

endmodule
